>>> design/cds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants of the conveyor diverter scheduler.
// ----------------------------------------------------------------------------
package cds_pkg;

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      REG_DELAY_A   = 2'd0,
      REG_DELAY_B   = 2'd1,
      REG_SPEED_MAX = 2'd2,
      REG_RAMP_STEP = 2'd3
   } reg_index_type;

   localparam logic [19:0] DELAY_A_RESET   = 20'd3500;
   localparam logic [19:0] DELAY_B_RESET   = 20'd1400;
   localparam logic [14:0] SPEED_MAX_RESET = 15'd1000;
   localparam logic [14:0] RAMP_STEP_RESET = 15'd10;

   // Package codes
   localparam logic [7:0] CODE_FIRST  = 8'h31;
   localparam logic [7:0] CODE_SECOND = 8'h32;
   localparam logic [7:0] CODE_NONE   = 8'hFF;

   // Item kinds
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_CODE = 1'b1;

   // Diverter selection stored with each slot
   typedef enum logic [1:0] {
      DIV_NONE   = 2'd0,
      DIV_FIRST  = 2'd1,
      DIV_SECOND = 2'd2
   } diverter_type;

   typedef struct packed {
      logic [19:0] delay_a;
      logic [19:0] delay_b;
      logic [14:0] speed_max;
      logic [14:0] ramp_step;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  target;
      logic        fired;
      logic [31:0] due;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

>>> design/cds_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_if
// Valid/ready channels for scheduler items and scheduler results.
// ----------------------------------------------------------------------------
interface cds_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] code;
   logic       enabled;

   modport source (output valid, output action, output code, output enabled, input ready);
   modport sink   (input valid, input action, input code, input enabled, output ready);
endinterface

interface cds_rsp_if;
   logic        valid;
   logic        ready;
   logic        fire_first;
   logic        fire_second;
   logic [14:0] motor_speed;
   logic [7:0]  shown_code;
   logic [7:0]  packages_seen;

   modport source (output valid, output fire_first, output fire_second,
                   output motor_speed, output shown_code, output packages_seen,
                   input ready);
   modport sink   (input valid, input fire_first, input fire_second,
                   input motor_speed, input shown_code, input packages_seen,
                   output ready);
endinterface
`default_nettype wire

>>> design/cds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> design/cds_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_csr
// Configuration registers behind an APB-style write/read port.
// ----------------------------------------------------------------------------
module cds_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [cds_pkg::CSR_AW-1:0] paddr,
   input  wire logic [cds_pkg::CSR_DW-1:0] pwdata,
   output logic      [cds_pkg::CSR_DW-1:0] prdata,
   output logic                            pready,
   output cds_pkg::cfg_type                cfg
);
   import cds_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type sel;
   logic          wr;

   assign sel    = reg_index_type'(paddr[3:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (sel)
            REG_DELAY_A:   cfg_in.delay_a   = pwdata[19:0];
            REG_DELAY_B:   cfg_in.delay_b   = pwdata[19:0];
            REG_SPEED_MAX: cfg_in.speed_max = pwdata[14:0];
            REG_RAMP_STEP: cfg_in.ramp_step = pwdata[14:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_DELAY_A:   prdata = {12'd0, cfg_ff.delay_a};
         REG_DELAY_B:   prdata = {12'd0, cfg_ff.delay_b};
         REG_SPEED_MAX: prdata = {17'd0, cfg_ff.speed_max};
         REG_RAMP_STEP: prdata = {17'd0, cfg_ff.ramp_step};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_a   <= DELAY_A_RESET;
         cfg_ff.delay_b   <= DELAY_B_RESET;
         cfg_ff.speed_max <= SPEED_MAX_RESET;
         cfg_ff.ramp_step <= RAMP_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> design/cds_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_engine
// Item sequencer: stores packages in the slot memory, scans the slots on
// each enabled tick with read-modify-write, ramps the motor and registers
// the result.
// ----------------------------------------------------------------------------
module cds_engine #(
   parameter int SLOTS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cds_pkg::cfg_type              cfg,
   cds_req_if.sink                            req,
   cds_rsp_if.source                          rsp,
   output logic                               mem_wr_en,
   output logic      [$clog2(SLOTS)-1:0]      mem_wr_addr,
   output cds_pkg::slot_type                  mem_wr_data,
   output logic                               mem_rd_en,
   output logic      [$clog2(SLOTS)-1:0]      mem_rd_addr,
   input  wire cds_pkg::slot_type             mem_rd_data
);
   import cds_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam logic [AW:0] SCAN_END = (AW + 1)'(SLOTS);
   localparam logic [AW-1:0] SLOT_LAST = AW'(SLOTS - 1);

   state_type   state_ff, state_in;
   logic [31:0] time_ff;
   logic [AW-1:0] wslot_ff;
   logic [14:0] ramp_ff;
   logic [7:0]  last_code_ff;
   logic [7:0]  total_ff;
   logic [SLOTS-1:0] valid_ff;

   logic [AW:0]   idx_ff;
   logic          chk_vld_ff;
   logic [AW-1:0] chk_addr_ff;
   logic          f1_ff, f2_ff;
   logic          en_ff;
   logic          tick_en_ff;

   logic        rsp_valid_ff;
   logic        rsp_f1_ff, rsp_f2_ff;
   logic [14:0] rsp_speed_ff;
   logic [7:0]  rsp_code_ff, rsp_total_ff;

   logic        accept;
   logic        out_free;
   logic        out_load;
   logic        scan_issue;
   logic        hit;
   logic [31:0] age;
   logic [15:0] ramp_sum;
   logic [14:0] ramp_next;
   logic [14:0] speed_out;
   slot_type    new_slot;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req.action == ACTION_TICK && req.enabled) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (idx_ff == SCAN_END) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req.ready  = 1'b0;
      scan_issue = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: req.ready  = 1'b1;
         ST_SCAN: scan_issue = (idx_ff != SCAN_END);
         ST_DONE: out_load   = out_free;
         default: req.ready  = 1'b0;
      endcase
   end

   // A slot fires when it is valid, has a diverter, has not fired yet, and the time
   // has reached its due time (sign of the wrapped difference is clear).
   assign age = time_ff - mem_rd_data.due;
   assign hit = chk_vld_ff && valid_ff[chk_addr_ff] && mem_rd_data.target != DIV_NONE
                && !mem_rd_data.fired && !age[31];

   always_comb begin
      new_slot.fired = 1'b0;
      if (req.code == CODE_FIRST) begin
         new_slot.target = DIV_FIRST;
         new_slot.due    = time_ff + {12'd0, cfg.delay_a};
      end else if (req.code == CODE_SECOND) begin
         new_slot.target = DIV_SECOND;
         new_slot.due    = time_ff + {12'd0, cfg.delay_b};
      end else begin
         new_slot.target = DIV_NONE;
         new_slot.due    = '0;
      end
   end

   // Scan reads address idx while the entry read in the previous cycle is checked
   // and written back, so read and write never meet on one entry.
   always_comb begin
      mem_rd_en   = scan_issue;
      mem_rd_addr = idx_ff[AW-1:0];
      if (accept && req.action == ACTION_CODE) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = wslot_ff;
         mem_wr_data = new_slot;
      end else begin
         mem_wr_en   = hit;
         mem_wr_addr = chk_addr_ff;
         mem_wr_data = mem_rd_data;
         mem_wr_data.fired = 1'b1;
      end
   end

   always_comb begin
      ramp_sum = {1'b0, ramp_ff} + {1'b0, cfg.ramp_step};
      if (ramp_ff < cfg.speed_max) begin
         ramp_next = (ramp_sum > {1'b0, cfg.speed_max}) ? cfg.speed_max : ramp_sum[14:0];
      end else begin
         ramp_next = cfg.speed_max;
      end
      if (!en_ff) begin
         speed_out = '0;
      end else if (tick_en_ff) begin
         speed_out = ramp_next;
      end else begin
         speed_out = ramp_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         wslot_ff     <= '0;
         ramp_ff      <= '0;
         last_code_ff <= CODE_NONE;
         total_ff     <= '0;
         valid_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= scan_issue;
         if (accept) begin
            if (req.action == ACTION_CODE) begin
               valid_ff[wslot_ff] <= 1'b1;
               wslot_ff     <= (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + 1'b1;
               last_code_ff <= req.code;
               total_ff     <= total_ff + 8'd1;
            end else begin
               time_ff <= time_ff + 32'd1;
            end
         end
         if (out_load && tick_en_ff) begin
            ramp_ff <= ramp_next;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-item working registers and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff     <= '0;
         f1_ff      <= 1'b0;
         f2_ff      <= 1'b0;
         en_ff      <= req.enabled;
         tick_en_ff <= req.action == ACTION_TICK && req.enabled;
      end else begin
         if (scan_issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (hit && mem_rd_data.target == DIV_FIRST) begin
            f1_ff <= 1'b1;
         end
         if (hit && mem_rd_data.target == DIV_SECOND) begin
            f2_ff <= 1'b1;
         end
      end
      chk_addr_ff <= idx_ff[AW-1:0];
      if (out_load) begin
         rsp_f1_ff    <= f1_ff;
         rsp_f2_ff    <= f2_ff;
         rsp_speed_ff <= speed_out;
         rsp_code_ff  <= last_code_ff;
         rsp_total_ff <= total_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.fire_first    = rsp_f1_ff;
   assign rsp.fire_second   = rsp_f2_ff;
   assign rsp.motor_speed   = rsp_speed_ff;
   assign rsp.shown_code    = rsp_code_ff;
   assign rsp.packages_seen = rsp_total_ff;

endmodule
`default_nettype wire

>>> design/conveyor_diverter_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conveyor_diverter_scheduler_top
// Sorting-conveyor scheduler: package slots in a RAM, diverter firing on
// ticks, motor soft-start ramp.
//
//   Channel  Direction  Handshake            Carries
//   req      in         valid/ready          action, code, enabled
//   rsp      out        valid/ready          fire bits, speed, code, count
//   csr      in         APB psel/penable     delay_a, delay_b, speed_max, ramp_step
//
// On an enabled tick the slot RAM is read one entry per cycle and each due
// entry is written back as fired; a code item or a disabled tick skips the
// scan. A new item is taken while the previous result waits in the output
// register; the sequencer stalls in its done state only until that register
// frees. Reset is synchronous and clears all control state and the per-slot
// valid bits at once.
// ----------------------------------------------------------------------------
module conveyor_diverter_scheduler_top #(
   parameter int SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   cds_req_if.sink                         req,
   cds_rsp_if.source                       rsp,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [cds_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [cds_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [cds_pkg::CSR_DW-1:0] csr_prdata,
   output logic                            csr_pready
);
   import cds_pkg::*;

   localparam int AW = $clog2(SLOTS);

   cfg_type       cfg;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   slot_type      mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   slot_type      mem_rd_data;

   cds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cds_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cds_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req),
      .rsp         (rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire

>>> design/cds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks of the scheduler's item and result channels.
// ----------------------------------------------------------------------------
module cds_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_fire_first,
   input wire logic        rsp_fire_second,
   input wire logic [14:0] rsp_motor_speed,
   input wire logic [7:0]  rsp_shown_code,
   input wire logic [7:0]  rsp_packages_seen
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       seen_ff;
   logic [7:0] count_ff;
   logic [7:0] code_ff;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (rsp_xfer) begin
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         count_ff <= rsp_packages_seen;
         code_ff  <= rsp_shown_code;
      end
   end

   // A held result keeps its payload until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fire_first)
         && $stable(rsp_fire_second) && $stable(rsp_motor_speed)
         && $stable(rsp_shown_code) && $stable(rsp_packages_seen))
      else $error("result changed while stalled");

   // Every result belongs to an accepted item.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a pending item");

   // At most the item in work and one waiting result are outstanding.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many outstanding items");

   // The package count moves by at most one from result to result.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_ff |-> rsp_packages_seen == count_ff
         || rsp_packages_seen == count_ff + 8'd1)
      else $error("package count skipped");

   // Without a new package the shown code stays put.
   a_code_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && seen_ff && rsp_packages_seen == count_ff |-> rsp_shown_code == code_ff)
      else $error("shown code changed without a package");

endmodule

bind conveyor_diverter_scheduler_top cds_checker u_cds_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_fire_first    (rsp.fire_first),
   .rsp_fire_second   (rsp.fire_second),
   .rsp_motor_speed   (rsp.motor_speed),
   .rsp_shown_code    (rsp.shown_code),
   .rsp_packages_seen (rsp.packages_seen)
);
`default_nettype wire
